// ===== design/eft_pkg.sv =====
// Shared types and constants for the elapsed-time-to-frame converter.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
package eft_pkg;
   localparam int UNIT_W = 64;
   localparam int CNT_W  = $clog2(UNIT_W) + 1;
   localparam logic [29:0] NS_PER_SEC = 30'd1000000000;
   localparam logic [31:0] FPS_NUM_RESET = 32'd30;
   localparam logic [31:0] FPS_DEN_RESET = 32'd1;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_INVALID  = 2'd1,
      ST_OVERFLOW = 2'd2,
      ST_RANGE    = 2'd3
   } status_type;

   typedef enum logic {
      REG_FPS_NUM = 1'b0,
      REG_FPS_DEN = 1'b1
   } reg_idx_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_GCD_GO,
      S_GCD_WAIT,
      S_DF_GO,
      S_DF_WAIT,
      S_DD_GO,
      S_DD_WAIT,
      S_MN_GO,
      S_MN_WAIT,
      S_MD_GO,
      S_MD_WAIT,
      S_Q_GO,
      S_Q_WAIT,
      S_DONE
   } seq_state_type;
endpackage

// ===== design/eft_gcd.sv =====
// Binary gcd unit, one shift or subtract step per cycle.
// Depends on eft_pkg.
`timescale 1ns / 1ps
module eft_gcd import eft_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [UNIT_W-1:0] a,
   input  logic [UNIT_W-1:0] b,
   output logic              done,
   output logic [UNIT_W-1:0] g
);
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [UNIT_W-1:0] a_ff, a_in, b_ff, b_in, g_ff, g_in;
   logic [CNT_W-1:0]  k_ff, k_in;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      a_in    = a_ff;
      b_in    = b_ff;
      k_in    = k_ff;
      g_in    = g_ff;
      if (start) begin
         busy_in = 1'b1;
         a_in    = a;
         b_in    = b;
         k_in    = '0;
      end else if (busy_ff) begin
         if (a_ff == '0) begin
            g_in    = b_ff << k_ff;
            busy_in = 1'b0;
            done_in = 1'b1;
         end else if (b_ff == '0) begin
            g_in    = a_ff << k_ff;
            busy_in = 1'b0;
            done_in = 1'b1;
         end else if (!a_ff[0] && !b_ff[0]) begin
            a_in = a_ff >> 1;
            b_in = b_ff >> 1;
            k_in = k_ff + 1'b1;
         end else if (!a_ff[0]) begin
            a_in = a_ff >> 1;
         end else if (!b_ff[0]) begin
            b_in = b_ff >> 1;
         end else if (a_ff > b_ff) begin
            a_in = a_ff - b_ff;
         end else begin
            b_in = b_ff - a_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      a_ff <= a_in;
      b_ff <= b_in;
      k_ff <= k_in;
      g_ff <= g_in;
   end

   assign done = done_ff;
   assign g    = g_ff;
endmodule

// ===== design/eft_div.sv =====
// Restoring divider, one quotient bit per cycle.
// Depends on eft_pkg.
`timescale 1ns / 1ps
module eft_div import eft_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [UNIT_W-1:0] n,
   input  logic [UNIT_W-1:0] d,
   output logic              done,
   output logic [UNIT_W-1:0] q
);
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [UNIT_W-1:0] q_ff, q_in, r_ff, r_in, d_ff, d_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [UNIT_W:0]   trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      q_in    = q_ff;
      r_in    = r_ff;
      d_in    = d_ff;
      cnt_in  = cnt_ff;
      trial   = {r_ff, q_ff[UNIT_W-1]};
      if (start) begin
         busy_in = 1'b1;
         q_in    = n;
         r_in    = '0;
         d_in    = d;
         cnt_in  = '0;
      end else if (busy_ff) begin
         if (trial >= {1'b0, d_ff}) begin
            r_in = UNIT_W'(trial - {1'b0, d_ff});
            q_in = {q_ff[UNIT_W-2:0], 1'b1};
         end else begin
            r_in = trial[UNIT_W-1:0];
            q_in = {q_ff[UNIT_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(UNIT_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      q_ff <= q_in;
      r_ff <= r_in;
      d_ff <= d_in;
   end

   assign done = done_ff;
   assign q    = q_ff;
endmodule

// ===== design/eft_mul.sv =====
// Shift-add multiplier with unsigned overflow flag, one multiplier bit per cycle.
// Depends on eft_pkg.
`timescale 1ns / 1ps
module eft_mul import eft_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [UNIT_W-1:0] a,
   input  logic [UNIT_W-1:0] b,
   output logic              done,
   output logic [UNIT_W-1:0] p,
   output logic              ovf
);
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [UNIT_W-1:0] m_ff, m_in, b_ff, b_in, acc_ff, acc_in;
   logic              mhi_ff, mhi_in, ovf_ff, ovf_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [UNIT_W:0]   sum;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      m_in    = m_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;
      mhi_in  = mhi_ff;
      ovf_in  = ovf_ff;
      cnt_in  = cnt_ff;
      sum     = {1'b0, acc_ff} + {1'b0, m_ff};
      if (start) begin
         busy_in = 1'b1;
         m_in    = a;
         b_in    = b;
         acc_in  = '0;
         mhi_in  = 1'b0;
         ovf_in  = 1'b0;
         cnt_in  = '0;
      end else if (busy_ff) begin
         if (b_ff[0]) begin
            acc_in = sum[UNIT_W-1:0];
            ovf_in = ovf_ff | mhi_ff | sum[UNIT_W];
         end
         mhi_in = mhi_ff | m_ff[UNIT_W-1];
         m_in   = m_ff << 1;
         b_in   = b_ff >> 1;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(UNIT_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      m_ff   <= m_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
      mhi_ff <= mhi_in;
      ovf_ff <= ovf_in;
   end

   assign done = done_ff;
   assign p    = acc_ff;
   assign ovf  = ovf_ff;
endmodule

// ===== design/elapsed_time_to_frame.sv =====
// Per valid beat: four gcd runs (one step per cycle), eight serial divisions and two
// multiplies, then a ninth division unless a product overflows or the divisor product is 0.
// Throughput: one item at a time; the next beat is taken once the sequencer is idle,
// even while the previous result still waits on rsp. Invalid operands go straight to done.
// Reset (synchronous): sequencer idle, no result pending, fps 30/1.
`timescale 1ns / 1ps
module elapsed_time_to_frame import eft_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [127:0] req_tdata,   // base_frame[63:0], elapsed_ns[127:64]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [71:0]  rsp_tdata,   // frame[62:0], status[64:63], zero pad
   input  logic         csr_wen,
   input  logic         csr_idx,
   input  logic [31:0]  csr_wdata
);
   seq_state_type state_ff, state_in;
   logic [31:0] fnum_ff, fden_ff;
   logic [62:0] fac0_ff, fac0_in, base_ff, base_in;
   logic [31:0] fac1_ff, fac1_in, div1_ff, div1_in;
   logic [29:0] div0_ff, div0_in;
   logic [1:0]  ij_ff, ij_in;
   logic [63:0] num_ff, num_in;
   logic        ovf_ff, ovf_in;
   logic [62:0] res_frame_ff, res_frame_in;
   status_type  res_status_ff, res_status_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [62:0] rsp_frame_ff, rsp_frame_in;
   status_type  rsp_status_ff, rsp_status_in;

   logic              accept, bad_in, load_rsp;
   logic              gcd_start, div_start, mul_start;
   logic              gcd_done, div_done, mul_done, mul_ovf;
   logic [UNIT_W-1:0] gcd_a, gcd_b, gcd_g, div_n, div_d, div_q, mul_a, mul_b, mul_p;
   logic [UNIT_W-1:0] fac_sel, div_sel;
   logic [63:0]       sum;

   assign accept   = req_tvalid && req_tready;
   assign bad_in   = req_tdata[63] || req_tdata[127] || fnum_ff == '0 || fden_ff == '0;
   assign load_rsp = state_ff == S_DONE && (!rsp_valid_ff || rsp_tready);
   assign fac_sel  = ij_ff[0] ? UNIT_W'(fac1_ff) : UNIT_W'(fac0_ff);
   assign div_sel  = ij_ff[1] ? UNIT_W'(div1_ff) : UNIT_W'(div0_ff);
   assign sum      = {1'b0, base_ff} + div_q;

   eft_gcd u_gcd (.clock, .reset, .start(gcd_start), .a(gcd_a), .b(gcd_b),
                  .done(gcd_done), .g(gcd_g));
   eft_div u_div (.clock, .reset, .start(div_start), .n(div_n), .d(div_d),
                  .done(div_done), .q(div_q));
   eft_mul u_mul (.clock, .reset, .start(mul_start), .a(mul_a), .b(mul_b),
                  .done(mul_done), .p(mul_p), .ovf(mul_ovf));

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:     if (accept) state_in = bad_in ? S_DONE : S_GCD_GO;
         S_GCD_GO:   state_in = S_GCD_WAIT;
         S_GCD_WAIT: if (gcd_done) state_in = S_DF_GO;
         S_DF_GO:    state_in = S_DF_WAIT;
         S_DF_WAIT:  if (div_done) state_in = S_DD_GO;
         S_DD_GO:    state_in = S_DD_WAIT;
         S_DD_WAIT:  if (div_done) state_in = (ij_ff == 2'b11) ? S_MN_GO : S_GCD_GO;
         S_MN_GO:    state_in = S_MN_WAIT;
         S_MN_WAIT:  if (mul_done) state_in = S_MD_GO;
         S_MD_GO:    state_in = S_MD_WAIT;
         S_MD_WAIT: begin
            if (mul_done) state_in = (ovf_ff || mul_ovf || mul_p == '0) ? S_DONE : S_Q_GO;
         end
         S_Q_GO:     state_in = S_Q_WAIT;
         S_Q_WAIT:   if (div_done) state_in = S_DONE;
         S_DONE:     if (load_rsp) state_in = S_IDLE;
         default:    state_in = S_IDLE;
      endcase
   end

   always_comb begin
      req_tready    = state_ff == S_IDLE;
      gcd_start     = state_ff == S_GCD_GO;
      div_start     = state_ff == S_DF_GO || state_ff == S_DD_GO || state_ff == S_Q_GO;
      mul_start     = state_ff == S_MN_GO || state_ff == S_MD_GO;
      gcd_a         = fac_sel;
      gcd_b         = div_sel;
      div_n         = fac_sel;
      div_d         = gcd_g;
      mul_a         = UNIT_W'(fac0_ff);
      mul_b         = UNIT_W'(fac1_ff);
      fac0_in       = fac0_ff;
      fac1_in       = fac1_ff;
      div0_in       = div0_ff;
      div1_in       = div1_ff;
      base_in       = base_ff;
      ij_in         = ij_ff;
      num_in        = num_ff;
      ovf_in        = ovf_ff;
      res_frame_in  = res_frame_ff;
      res_status_in = res_status_ff;
      unique case (state_ff)
         S_IDLE: begin
            fac0_in = req_tdata[126:64];
            fac1_in = fnum_ff;
            div0_in = NS_PER_SEC;
            div1_in = fden_ff;
            base_in = req_tdata[62:0];
            ij_in   = '0;
            if (accept && bad_in) begin
               res_frame_in  = '0;
               res_status_in = ST_INVALID;
            end
         end
         S_DF_WAIT: begin
            if (div_done) begin
               if (ij_ff[0]) fac1_in = div_q[31:0];
               else          fac0_in = div_q[62:0];
            end
         end
         S_DD_GO, S_DD_WAIT: begin
            div_n = div_sel;
            if (state_ff == S_DD_WAIT && div_done) begin
               if (ij_ff[1]) div1_in = div_q[31:0];
               else          div0_in = div_q[29:0];
               ij_in = ij_ff + 1'b1;
            end
         end
         S_MN_WAIT: begin
            if (mul_done) begin
               num_in = mul_p;
               ovf_in = mul_ovf;
            end
         end
         S_MD_GO, S_MD_WAIT: begin
            mul_a = UNIT_W'(div0_ff);
            mul_b = UNIT_W'(div1_ff);
            if (state_ff == S_MD_WAIT && mul_done &&
                (ovf_ff || mul_ovf || mul_p == '0)) begin
               res_frame_in  = '0;
               res_status_in = ST_OVERFLOW;
            end
         end
         S_Q_GO, S_Q_WAIT: begin
            div_n = num_ff;
            div_d = mul_p;
            if (state_ff == S_Q_WAIT && div_done) begin
               if (div_q[63] || sum[63]) begin
                  res_frame_in  = '0;
                  res_status_in = ST_RANGE;
               end else begin
                  res_frame_in  = sum[62:0];
                  res_status_in = ST_OK;
               end
            end
         end
         default: begin
         end
      endcase
      rsp_valid_in  = load_rsp || (rsp_valid_ff && !rsp_tready);
      rsp_frame_in  = load_rsp ? res_frame_ff : rsp_frame_ff;
      rsp_status_in = load_rsp ? res_status_ff : rsp_status_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         fnum_ff      <= FPS_NUM_RESET;
         fden_ff      <= FPS_DEN_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wen && csr_idx == REG_FPS_NUM) fnum_ff <= csr_wdata;
         if (csr_wen && csr_idx == REG_FPS_DEN) fden_ff <= csr_wdata;
      end
      fac0_ff       <= fac0_in;
      fac1_ff       <= fac1_in;
      div0_ff       <= div0_in;
      div1_ff       <= div1_in;
      base_ff       <= base_in;
      ij_ff         <= ij_in;
      num_ff        <= num_in;
      ovf_ff        <= ovf_in;
      res_frame_ff  <= res_frame_in;
      res_status_ff <= res_status_in;
      rsp_frame_ff  <= rsp_frame_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_status_ff, rsp_frame_ff};

   a_err_zero_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff != ST_OK |-> rsp_frame_ff == '0)
      else $error("nonzero frame with error status");
   a_bad_to_done: assert property (@(posedge clock) disable iff (reset)
      accept && bad_in |=> state_ff == S_DONE && res_status_ff == ST_INVALID)
      else $error("invalid operand not reported");
   a_good_starts: assert property (@(posedge clock) disable iff (reset)
      accept && !bad_in |=> state_ff == S_GCD_GO && ij_ff == 2'b00)
      else $error("reduction did not start");
   a_done_leaves: assert property (@(posedge clock) disable iff (reset)
      load_rsp |=> rsp_valid_ff && state_ff == S_IDLE)
      else $error("result not presented");
endmodule

// ===== sim/tb.sv =====
// Self-checking bench for elapsed_time_to_frame: directed corner cases, then random
// beats under several frame rates, checked against a rational rescale predictor.
// Depends on eft_pkg and the elapsed_time_to_frame RTL only.
`timescale 1ns / 1ps

class frame_scoreboard;
   typedef struct {
      logic [62:0]         frame;
      eft_pkg::status_type status;
   } frame_result_type;

   frame_result_type frames_due[$];
   logic [31:0]      fps_num;
   logic [31:0]      fps_den;
   int               errors;

   function new();
      fps_num = eft_pkg::FPS_NUM_RESET;
      fps_den = eft_pkg::FPS_DEN_RESET;
      errors  = 0;
   endfunction

   task report(string msg);
      errors++;
      $display("MISMATCH @%0t: %s", $realtime, msg);
   endtask

   function logic [63:0] gcd64(logic [63:0] a, logic [63:0] b);
      logic [63:0] r;
      while (b != 0) begin
         r = a % b;
         a = b;
         b = r;
      end
      return a;
   endfunction

   function void note_beat(logic [63:0] base, logic [63:0] elapsed);
      frame_result_type r;
      logic [63:0]   fac [2];
      logic [63:0]   dv [2];
      logic [63:0]   g;
      logic [127:0]  pn;
      logic [127:0]  pd;
      logic [63:0]   adv;
      logic [63:0]   top;
      top = 64'h7FFF_FFFF_FFFF_FFFF;
      r.frame = '0;
      r.status = eft_pkg::ST_OK;
      if (base[63] || elapsed[63] || fps_num == 0 || fps_den == 0) begin
         r.status = eft_pkg::ST_INVALID;
      end else begin
         fac[0] = elapsed;
         fac[1] = {32'd0, fps_num};
         dv[0]  = 64'd1000000000;
         dv[1]  = {32'd0, fps_den};
         for (int i = 0; i < 2; i++)
            for (int j = 0; j < 2; j++) begin
               g = gcd64(fac[j], dv[i]);
               if (g != 0) begin
                  fac[j] = fac[j] / g;
                  dv[i]  = dv[i] / g;
               end
            end
         pn = {64'd0, fac[0]} * {64'd0, fac[1]};
         pd = {64'd0, dv[0]} * {64'd0, dv[1]};
         if (pn[127:64] != 0 || pd[127:64] != 0 || pd[63:0] == 0) begin
            r.status = eft_pkg::ST_OVERFLOW;
         end else begin
            adv = pn[63:0] / pd[63:0];
            if (adv > top || base > top - adv)
               r.status = eft_pkg::ST_RANGE;
            else
               r.frame = base[62:0] + adv[62:0];
         end
      end
      frames_due.push_back(r);
   endfunction

   task check_beat(logic [71:0] data);
      frame_result_type r;
      if (frames_due.size() == 0) begin
         report($sformatf("unexpected result %h", data));
         return;
      end
      r = frames_due.pop_front();
      if (data[64:63] != r.status)
         report($sformatf("status %0d, want %0d", data[64:63], r.status));
      if (data[62:0] != r.frame)
         report($sformatf("frame %0d, want %0d", data[62:0], r.frame));
   endtask

   function int pending();
      return frames_due.size();
   endfunction
endclass

module tb;
   import eft_pkg::*;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [127:0] req_tdata;   // base_frame[63:0], elapsed_ns[127:64]
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [71:0]  rsp_tdata;   // frame[62:0], status[64:63], zero pad
   logic         csr_wen;
   logic         csr_idx;
   logic [31:0]  csr_wdata;

   frame_scoreboard sb;
   bit              tx_quiet;
   bit              rx_quiet;
   int              rx_hold;

   elapsed_time_to_frame dut (.*);

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   initial begin
      #(200_000_000);
      $display("DONE: errors detected");
      $finish;
   end

   task automatic send_beat(logic [63:0] base, logic [63:0] elapsed);
      int gap;
      gap = tx_quiet ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {elapsed, base};
      do @(posedge clock); while (!req_tready);
      sb.note_beat(base, elapsed);
      @(negedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic csr_write(reg_idx_type idx, logic [31:0] value);
      csr_wen   <= 1'b1;
      csr_idx   <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_wen   <= 1'b0;
      if (idx == REG_FPS_NUM) sb.fps_num = value;
      else sb.fps_den = value;
   endtask

   task automatic set_rate(logic [31:0] num, logic [31:0] den);
      drain();
      csr_write(REG_FPS_NUM, num);
      csr_write(REG_FPS_DEN, den);
   endtask

   function automatic logic [63:0] rand_operand();
      logic [63:0] v;
      v = {$urandom, $urandom};
      if ($urandom_range(0, 15) == 0) return v | 64'h8000_0000_0000_0000;
      return v & (64'h7FFF_FFFF_FFFF_FFFF >> $urandom_range(0, 63));
   endfunction

   // receiver: random stall per beat, plus one long hold-off
   initial begin
      int stall;
      rsp_tready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         stall = rx_quiet ? 0 : $urandom_range(0, 14);
         stall += rx_hold;
         rx_hold = 0;
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         sb.check_beat(rsp_tdata);
         @(negedge clock);
      end
   end

   initial begin
      logic [63:0] top;
      logic [31:0] rates [9][2];
      top = 64'h7FFF_FFFF_FFFF_FFFF;
      sb = new();
      tx_quiet = 0;
      rx_quiet = 0;
      rx_hold = 0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_wen = 1'b0;
      csr_idx = REG_FPS_NUM;
      csr_wdata = '0;
      repeat (3) @(negedge clock);
      reset = 1'b0;

      // reset rate 30/1
      send_beat(0, 0);
      send_beat(5, 0);
      send_beat(64'hFFFF_FFFF_FFFF_FFFF, 1);
      send_beat(0, 64'h8000_0000_0000_0000);
      send_beat(64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000);
      send_beat(top, 0);
      send_beat(top, 64'd1000000000);
      send_beat(0, top);
      send_beat(top, top);
      send_beat(0, 64'd1000000000);
      send_beat(0, 64'd999999999);
      send_beat(7, 64'd1000000000000000000);
      set_rate(32'hFFFF_FFFF, 1);
      send_beat(0, 64'd4000000000000000000);
      send_beat(0, 64'd2000000000000000000);
      send_beat(top - 64'd5, 64'd2000000000000000000);
      set_rate(0, 1);
      send_beat(1, 1);
      set_rate(1, 0);
      send_beat(1, 1);
      set_rate(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_beat(3, 64'd123456789);
      send_beat(3, top);

      rates = '{'{24000, 1001}, '{30000, 1001}, '{60, 1}, '{1, 32'hFFFF_FFFF},
                '{32'hFFFF_FFFF, 1}, '{0, 0}, '{25, 1},
                '{32'hFFFF_FFFF, 32'hFFFF_FFFF}, '{1, 1}};
      rates[5][0] = $urandom;
      rates[5][1] = $urandom_range(1, 5000);
      for (int p = 0; p < 9; p++) begin
         set_rate(rates[p][0], rates[p][1]);
         tx_quiet = ($urandom_range(0, 3) == 0);
         rx_quiet = ($urandom_range(0, 3) == 0);
         for (int k = 0; k < 115; k++) begin
            if (k == 40 && p == 2) begin
               rx_hold = 3000;
               tx_quiet = 1;
            end
            if (k == 70) begin
               req_tvalid <= 1'b0;
               while (sb.pending() != 0) @(negedge clock);
            end
            send_beat(rand_operand(), rand_operand());
         end
      end

      drain();
      repeat (1300) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end
endmodule

// ===== filelist.f =====
design/eft_pkg.sv
design/eft_gcd.sv
design/eft_div.sv
design/eft_mul.sv
design/elapsed_time_to_frame.sv
sim/tb.sv
